@@ rtl/dss_pkg.sv @@
// Shared types, register indexes and reset values for the dual solenoid fire sequencer.
`default_nettype none

package dss_pkg;

    localparam int unsigned CNT_W    = 16;
    localparam int unsigned POS_W    = 10;
    localparam int unsigned DUTY_W   = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRE_INTERVAL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOLENOID_ON_TIME  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLYWHEEL_DUTY     = 3'd4;

    localparam logic [POS_W-1:0]  RST_TRIGGER_THRESHOLD = 10'd20;
    localparam logic [CNT_W-1:0]  RST_SAMPLE_INTERVAL   = 16'd50;
    localparam logic [CNT_W-1:0]  RST_FIRE_INTERVAL     = 16'd250;
    localparam logic [CNT_W-1:0]  RST_SOLENOID_ON_TIME  = 16'd300;
    localparam logic [DUTY_W-1:0] RST_FLYWHEEL_DUTY     = 8'd20;

    localparam logic [CNT_W-1:0]  CNT_MAX = '1;

    typedef struct packed {
        logic [POS_W-1:0]  trigger_threshold;
        logic [CNT_W-1:0]  sample_interval;
        logic [CNT_W-1:0]  fire_interval;
        logic [CNT_W-1:0]  solenoid_on_time;
        logic [DUTY_W-1:0] flywheel_duty;
    } t_cfg;

    typedef struct packed {
        logic              out_of_sequence;
        logic              right_coil;
        logic              left_coil;
        logic [DUTY_W-1:0] flywheel_drive;
    } t_result;

    // Saturating increment of an elapsed counter
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        bump = (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage

`default_nettype wire

@@ rtl/dual_solenoid_fire_sequencer.sv @@
// Top level of the dual solenoid fire sequencer: stream ports, config bank, core, result register.
`default_nettype none

// Each input transaction is one millisecond tick; the block returns exactly one result per
// tick, in the cycle after it is taken, and accepts a new tick every clock. The state update
// is a single pass of compares and saturating counter steps from the state registers into
// the result register; the input side stalls only while a held result is not taken.
// Configuration is written through a plain write port and must only change while idle.

module dual_solenoid_fire_sequencer (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [dss_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire logic [dss_pkg::CFG_DAT_W-1:0]    i_cfg_wdata,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [0] rev_pressed, [10:1] trigger_position, [15:11] zero
    input  wire logic [dss_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [7:0] flywheel_drive, [8] left_coil, [9] right_coil, [10] out_of_sequence,
    // [15:11] zero
    output logic [dss_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

    localparam int unsigned RES_W = $bits(dss_pkg::t_result);

    dss_pkg::t_cfg    w_cfg;
    dss_pkg::t_result w_result;
    logic             w_accept;
    logic             r_out_valid;
    dss_pkg::t_result r_out;

    dss_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // Take a tick whenever the result register is empty or draining
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    dss_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (w_cfg),
        .i_tick             (w_accept),
        .i_rev_pressed      (s_axis_tdata[0]),
        .i_trigger_position (s_axis_tdata[dss_pkg::POS_W:1]),
        .o_result           (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(dss_pkg::OUT_TDATA_W - RES_W){1'b0}}, r_out};

endmodule

`default_nettype wire

@@ rtl/dss_cfg_regs.sv @@
// Configuration register bank of the fire sequencer.
`default_nettype none

module dss_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [dss_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [dss_pkg::CFG_DAT_W-1:0]  i_cfg_wdata,
    output dss_pkg::t_cfg                       o_cfg
);

    dss_pkg::t_cfg r_cfg;
    dss_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                dss_pkg::REG_TRIGGER_THRESHOLD:
                    n_cfg.trigger_threshold = i_cfg_wdata[dss_pkg::POS_W-1:0];
                dss_pkg::REG_SAMPLE_INTERVAL:  n_cfg.sample_interval  = i_cfg_wdata;
                dss_pkg::REG_FIRE_INTERVAL:    n_cfg.fire_interval    = i_cfg_wdata;
                dss_pkg::REG_SOLENOID_ON_TIME: n_cfg.solenoid_on_time = i_cfg_wdata;
                dss_pkg::REG_FLYWHEEL_DUTY:
                    n_cfg.flywheel_duty = i_cfg_wdata[dss_pkg::DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_threshold <= dss_pkg::RST_TRIGGER_THRESHOLD;
            r_cfg.sample_interval   <= dss_pkg::RST_SAMPLE_INTERVAL;
            r_cfg.fire_interval     <= dss_pkg::RST_FIRE_INTERVAL;
            r_cfg.solenoid_on_time  <= dss_pkg::RST_SOLENOID_ON_TIME;
            r_cfg.flywheel_duty     <= dss_pkg::RST_FLYWHEEL_DUTY;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/dss_core.sv @@
// Per-tick state update: elapsed counters, sampling, fault flag, firing and release.
`default_nettype none

module dss_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire dss_pkg::t_cfg              i_cfg,
    input  wire logic                       i_tick,
    input  wire logic                       i_rev_pressed,
    input  wire logic [dss_pkg::POS_W-1:0]  i_trigger_position,
    output dss_pkg::t_result                o_result
);

    logic [dss_pkg::CNT_W-1:0] r_sample_elapsed, n_sample_elapsed;
    logic [dss_pkg::CNT_W-1:0] r_fire_elapsed,   n_fire_elapsed;
    logic [dss_pkg::CNT_W-1:0] r_left_elapsed,   n_left_elapsed;
    logic [dss_pkg::CNT_W-1:0] r_right_elapsed,  n_right_elapsed;
    logic                      r_rev_latched,    n_rev_latched;
    logic [dss_pkg::POS_W-1:0] r_trigger_latched, n_trigger_latched;
    logic                      r_sequence_fault, n_sequence_fault;
    logic                      r_left_fired_last, n_left_fired_last;
    logic                      r_left_firing,    n_left_firing;
    logic                      r_right_firing,   n_right_firing;
    logic                      r_drive_on,       n_drive_on;

    always_comb begin
        n_sample_elapsed  = dss_pkg::bump(r_sample_elapsed);
        n_fire_elapsed    = dss_pkg::bump(r_fire_elapsed);
        n_left_elapsed    = dss_pkg::bump(r_left_elapsed);
        n_right_elapsed   = dss_pkg::bump(r_right_elapsed);
        n_rev_latched     = r_rev_latched;
        n_trigger_latched = r_trigger_latched;
        n_sequence_fault  = r_sequence_fault;
        n_left_fired_last = r_left_fired_last;
        n_left_firing     = r_left_firing;
        n_right_firing    = r_right_firing;
        n_drive_on        = r_drive_on;

        // Sample the button and trigger once per interval
        if (n_sample_elapsed >= i_cfg.sample_interval) begin
            n_sample_elapsed  = '0;
            n_trigger_latched = i_trigger_position;
            if (i_trigger_position > i_cfg.trigger_threshold) begin
                n_sequence_fault = 1'b0;
            end else if (i_trigger_position < i_cfg.trigger_threshold && !i_rev_pressed) begin
                n_sequence_fault = 1'b1;
            end
            n_rev_latched = i_rev_pressed && !n_sequence_fault;
            n_drive_on    = n_rev_latched;
        end

        // Fire the side that did not fire last
        if (n_trigger_latched < i_cfg.trigger_threshold && n_rev_latched &&
            n_fire_elapsed >= i_cfg.fire_interval) begin
            n_fire_elapsed = '0;
            if (r_left_fired_last) begin
                n_right_elapsed = '0;
                n_right_firing  = 1'b1;
            end else begin
                n_left_elapsed = '0;
                n_left_firing  = 1'b1;
            end
            n_left_fired_last = !r_left_fired_last;
        end

        if (n_right_firing && n_right_elapsed >= i_cfg.solenoid_on_time) begin
            n_right_elapsed = '0;
            n_right_firing  = 1'b0;
        end
        if (n_left_firing && n_left_elapsed >= i_cfg.solenoid_on_time) begin
            n_left_elapsed = '0;
            n_left_firing  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_elapsed  <= '0;
            r_fire_elapsed    <= '0;
            r_left_elapsed    <= '0;
            r_right_elapsed   <= '0;
            r_rev_latched     <= 1'b0;
            r_trigger_latched <= '0;
            r_sequence_fault  <= 1'b0;
            r_left_fired_last <= 1'b0;
            r_left_firing     <= 1'b0;
            r_right_firing    <= 1'b0;
            r_drive_on        <= 1'b0;
        end else if (i_tick) begin
            r_sample_elapsed  <= n_sample_elapsed;
            r_fire_elapsed    <= n_fire_elapsed;
            r_left_elapsed    <= n_left_elapsed;
            r_right_elapsed   <= n_right_elapsed;
            r_rev_latched     <= n_rev_latched;
            r_trigger_latched <= n_trigger_latched;
            r_sequence_fault  <= n_sequence_fault;
            r_left_fired_last <= n_left_fired_last;
            r_left_firing     <= n_left_firing;
            r_right_firing    <= n_right_firing;
            r_drive_on        <= n_drive_on;
        end
    end

    assign o_result.flywheel_drive  = n_drive_on ? i_cfg.flywheel_duty : '0;
    assign o_result.left_coil       = n_left_firing;
    assign o_result.right_coil      = n_right_firing;
    assign o_result.out_of_sequence = n_sequence_fault;

endmodule

`default_nettype wire

@@ rtl/dss_checker.sv @@
// Port-level checks on the fire sequencer, bound to the top level.
`default_nettype none

module dss_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [dss_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // A held result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // An empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // A fault forces rev off, so the flywheels are never driven while it is flagged
    a_no_drive_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[7:0] == 8'd0)
        else $error("flywheels driven during out-of-sequence fault");

    // Each accepted tick yields a result in the next cycle
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted tick produced no result");

endmodule

bind dual_solenoid_fire_sequencer dss_checker u_dss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
